[hw/rtl/lcwtc_pkg.sv]
// Shared types, widths and codes for the load-cell weigh, tare and calibrate unit.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lcwtc_pkg;

    // Field and datapath widths. The sum and numerator widths cover groups of up to eight samples.
    localparam int RAW_W     = 24;
    localparam int SUM_W     = 27;
    localparam int NUM_W     = 33;
    localparam int DVD_W     = 32;
    localparam int DVS_W     = 16;
    localparam int RES_W     = 25;
    localparam int RATIO_W   = 24;
    localparam int KW_W      = 16;
    localparam int REFF_W    = 9;
    localparam int TDATA_W   = 32;
    localparam int TUSER_W   = 3;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam int WEIGH_SAMPLES_DEF = 3;
    localparam int CAL_SAMPLES_DEF   = 5;

    // Mode codes; the result kind uses the same codes.
    localparam logic [1:0] MODE_WEIGH = 2'd0;
    localparam logic [1:0] MODE_TARE  = 2'd1;
    localparam logic [1:0] MODE_CAL   = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_ZERO   = 2'd1;
    localparam logic [1:0] REG_RATIO  = 2'd2;
    localparam logic [1:0] REG_KNOWN  = 2'd3;

    localparam logic [RATIO_W-1:0] RATIO_LOW   = RATIO_W'(400);
    localparam logic [RATIO_W-1:0] RATIO_HIGH  = RATIO_W'(440);
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(424);
    localparam logic [REFF_W-1:0]  RATIO_DEF   = REFF_W'(424);

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [RAW_W-1:0]   zero_offset;
        logic [RATIO_W-1:0]        scale_ratio;
        logic [KW_W-1:0]           known_weight;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_START,
        ST_WAIT,
        ST_POST,
        ST_DONE
    } t_state;

endpackage

[hw/rtl/lcwtc_regs.sv]
// Configuration register file behind the APB-style port.
// Depends on lcwtc_pkg for widths, register indexes and the configuration struct.
module lcwtc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [lcwtc_pkg::APB_AW-1:0]  i_paddr,
    input  logic [lcwtc_pkg::APB_DW-1:0]  i_pwdata,
    output logic [lcwtc_pkg::APB_DW-1:0]  o_prdata,
    output logic                          o_pready,
    output lcwtc_pkg::t_cfg               o_cfg,
    output logic                          o_mode_wr
);

    logic                                  w_wr;
    logic [1:0]                            w_idx;
    logic [1:0]                            r_mode;
    logic signed [lcwtc_pkg::RAW_W-1:0]    r_zero;
    logic [lcwtc_pkg::RATIO_W-1:0]         r_ratio;
    logic [lcwtc_pkg::KW_W-1:0]            r_known;

    assign w_wr      = i_psel & i_penable & i_pwrite;
    assign w_idx     = i_paddr[3:2];
    assign o_pready  = 1'b1;
    assign o_mode_wr = w_wr && (w_idx == lcwtc_pkg::REG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lcwtc_pkg::MODE_WEIGH;
            r_zero  <= '0;
            r_ratio <= lcwtc_pkg::RATIO_RESET;
            r_known <= lcwtc_pkg::KW_W'(1);
        end else if (w_wr) begin
            case (w_idx)
                lcwtc_pkg::REG_MODE:  r_mode  <= i_pwdata[1:0];
                lcwtc_pkg::REG_ZERO:  r_zero  <= i_pwdata[lcwtc_pkg::RAW_W-1:0];
                lcwtc_pkg::REG_RATIO: r_ratio <= i_pwdata[lcwtc_pkg::RATIO_W-1:0];
                lcwtc_pkg::REG_KNOWN: r_known <= i_pwdata[lcwtc_pkg::KW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            lcwtc_pkg::REG_MODE:  o_prdata = lcwtc_pkg::APB_DW'(r_mode);
            lcwtc_pkg::REG_ZERO:  o_prdata = lcwtc_pkg::APB_DW'(unsigned'(r_zero));
            lcwtc_pkg::REG_RATIO: o_prdata = lcwtc_pkg::APB_DW'(r_ratio);
            lcwtc_pkg::REG_KNOWN: o_prdata = lcwtc_pkg::APB_DW'(r_known);
            default:              o_prdata = '0;
        endcase
    end

    assign o_cfg.mode         = r_mode;
    assign o_cfg.zero_offset  = r_zero;
    assign o_cfg.scale_ratio  = r_ratio;
    assign o_cfg.known_weight = r_known;

endmodule

[hw/rtl/lcwtc_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle from a shifting dividend register.
// Depends on lcwtc_pkg for operand widths and the request struct.
module lcwtc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcwtc_pkg::t_div_req           i_req,
    output logic                          o_done,
    output logic [lcwtc_pkg::DVD_W-1:0]   o_quot
);

    localparam int DVD_W = lcwtc_pkg::DVD_W;
    localparam int DVS_W = lcwtc_pkg::DVS_W;
    localparam int CNT_W = $clog2(DVD_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DVS_W-1:0]   r_rem;
    logic [DVS_W-1:0]   r_dvs;
    logic [DVD_W-1:0]   r_quo;
    logic [DVS_W:0]     w_trial;
    logic [DVS_W:0]     w_diff;
    logic               w_ge;

    // The partial remainder always stays below the divisor, so it fits in DVS_W bits.
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[hw/rtl/load_cell_weigh_tare_calibrate_unit.sv]
// Top level of the load-cell weigh, tare and calibrate unit: sample accumulator, sequencer
// and output register. Depends on lcwtc_pkg, lcwtc_regs and lcwtc_div.
//
// Usage. Raw 24-bit converter codes arrive as transfers on the slave stream (i_s_*). Each is
// sign-extended and added into a running group sum in the cycle it is accepted. When a group is
// complete (WEIGH_SAMPLES samples in weigh mode, CAL_SAMPLES in tare and calibrate mode) the
// sequencer works out one result and offers it as a transfer on the master stream (o_m_*):
// tdata carries the signed 25-bit value, tuser the result kind and the ratio-replaced flag.
// Mode 3 accepts samples and discards them.
// Flow: an input that does not complete a group is added to the sum and the next may follow
// at once. A completing input starts the sequencer: prepare, scale (weigh mode only), then the
// bit-serial divider, one quotient bit per cycle. Weigh and tare results take one division,
// calibrate results two, or one when the known weight is zero.
// While the sequencer works the slave side is held not ready.
// Stalls: the finished result sits in an output register, so the block returns to accepting
// samples as soon as the result is loaded; only a second result waiting behind an unaccepted
// one holds the sequencer. Reset (synchronous, active low) clears the group and output valid
// and restores the register reset values. Writing the mode register clears the current group.
module load_cell_weigh_tare_calibrate_unit #(
    parameter int WEIGH_SAMPLES = lcwtc_pkg::WEIGH_SAMPLES_DEF,
    parameter int CAL_SAMPLES   = lcwtc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream. tdata: [23:0] raw_code.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lcwtc_pkg::RAW_W-1:0]     i_s_tdata,
    // Master stream. tdata: [24:0] result_value, [31:25] zero.
    // tuser: [1:0] result_kind, [2] ratio_replaced.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [lcwtc_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic [lcwtc_pkg::TUSER_W-1:0]   o_m_tuser,
    // Configuration port.
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [lcwtc_pkg::APB_AW-1:0]    i_paddr,
    input  logic [lcwtc_pkg::APB_DW-1:0]    i_pwdata,
    output logic [lcwtc_pkg::APB_DW-1:0]    o_prdata,
    output logic                            o_pready
);

    localparam int NUM_W = lcwtc_pkg::NUM_W;
    localparam int SUM_W = lcwtc_pkg::SUM_W;
    localparam int RES_W = lcwtc_pkg::RES_W;
    localparam int DVS_W = lcwtc_pkg::DVS_W;
    localparam int DVD_W = lcwtc_pkg::DVD_W;
    localparam int NMAX  = (WEIGH_SAMPLES > CAL_SAMPLES) ? WEIGH_SAMPLES : CAL_SAMPLES;
    localparam int CNT_W = $clog2(NMAX + 1);

    localparam logic [CNT_W-1:0] WEIGH_N = CNT_W'(WEIGH_SAMPLES);
    localparam logic [CNT_W-1:0] CAL_N   = CNT_W'(CAL_SAMPLES);

    lcwtc_pkg::t_cfg         w_cfg;
    logic                    w_mode_wr;
    lcwtc_pkg::t_div_req     w_req;
    logic                    w_div_done;
    logic [DVD_W-1:0]        w_quot;

    lcwtc_pkg::t_state       r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic [DVS_W-1:0]        r_den, n_den;
    logic                    r_neg, n_neg;
    logic                    r_second, n_second;
    logic [1:0]              r_kind, n_kind;
    logic                    r_repl, n_repl;
    logic signed [RES_W-1:0] r_res, n_res;
    logic                    r_m_valid, n_m_valid;
    logic signed [RES_W-1:0] r_m_value, n_m_value;
    logic [1:0]              r_m_kind, n_m_kind;
    logic                    r_m_repl, n_m_repl;

    logic signed [SUM_W-1:0] w_sum_tot;
    logic [CNT_W-1:0]        w_cnt_inc;
    logic [CNT_W-1:0]        w_need;
    logic signed [NUM_W-1:0] w_zo_ext;
    logic signed [NUM_W-1:0] w_nzo;
    logic                    w_in_range;
    logic [lcwtc_pkg::REFF_W-1:0] w_ratio_eff;
    logic [DVS_W-1:0]        w_nr;
    logic signed [NUM_W-1:0] w_abs;
    logic signed [NUM_W-1:0] w_q_signed;

    lcwtc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg),
        .o_mode_wr (w_mode_wr)
    );

    lcwtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // The raw code is two's complement, so a signed view of it is the sample.
    assign w_sum_tot = r_sum + SUM_W'($signed(i_s_tdata));
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_need    = (w_cfg.mode == lcwtc_pkg::MODE_WEIGH) ? WEIGH_N : CAL_N;

    // Weigh arithmetic: D = sum - N*zero, numerator 20*D + N*r, divisor 2*N*r.
    assign w_zo_ext    = NUM_W'($signed(w_cfg.zero_offset));
    assign w_nzo       = w_zo_ext * NUM_W'(WEIGH_SAMPLES);
    assign w_in_range  = (w_cfg.scale_ratio >= lcwtc_pkg::RATIO_LOW) &&
                         (w_cfg.scale_ratio <= lcwtc_pkg::RATIO_HIGH);
    assign w_ratio_eff = w_in_range ? w_cfg.scale_ratio[lcwtc_pkg::REFF_W-1:0]
                                    : lcwtc_pkg::RATIO_DEF;
    assign w_nr        = DVS_W'(w_ratio_eff) * DVS_W'(WEIGH_SAMPLES);

    // The divider works on magnitudes; the sign is put back afterwards so that the
    // quotient truncates towards zero.
    assign w_abs      = r_num[NUM_W-1] ? -r_num : r_num;
    assign w_q_signed = r_neg ? -NUM_W'(w_quot) : NUM_W'(w_quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lcwtc_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_second  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_sum     <= n_sum;
            r_second  <= n_second;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num     <= n_num;
        r_den     <= n_den;
        r_neg     <= n_neg;
        r_kind    <= n_kind;
        r_repl    <= n_repl;
        r_res     <= n_res;
        r_m_value <= n_m_value;
        r_m_kind  <= n_m_kind;
        r_m_repl  <= n_m_repl;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_num     = r_num;
        n_den     = r_den;
        n_neg     = r_neg;
        n_second  = r_second;
        n_kind    = r_kind;
        n_repl    = r_repl;
        n_res     = r_res;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_value = r_m_value;
        n_m_kind  = r_m_kind;
        n_m_repl  = r_m_repl;

        w_req.start    = 1'b0;
        w_req.dividend = w_abs[DVD_W-1:0];
        w_req.divisor  = r_den;

        o_s_tready = (r_state == lcwtc_pkg::ST_IDLE);

        case (r_state)
            lcwtc_pkg::ST_IDLE: begin
                if (i_s_tvalid && (w_cfg.mode inside {lcwtc_pkg::MODE_WEIGH,
                        lcwtc_pkg::MODE_TARE, lcwtc_pkg::MODE_CAL})) begin
                    if (w_cnt_inc >= w_need) begin
                        n_num    = NUM_W'(w_sum_tot);
                        n_sum    = '0;
                        n_cnt    = '0;
                        n_kind   = w_cfg.mode;
                        n_second = 1'b0;
                        n_state  = lcwtc_pkg::ST_PREP;
                    end else begin
                        n_sum = w_sum_tot;
                        n_cnt = w_cnt_inc;
                    end
                end
            end
            lcwtc_pkg::ST_PREP: begin
                if (r_kind == lcwtc_pkg::MODE_WEIGH) begin
                    n_num   = r_num - w_nzo;
                    n_repl  = !w_in_range;
                    n_state = lcwtc_pkg::ST_SCALE;
                end else begin
                    n_repl  = 1'b0;
                    n_den   = DVS_W'(CAL_SAMPLES);
                    n_state = lcwtc_pkg::ST_START;
                end
            end
            lcwtc_pkg::ST_SCALE: begin
                // Times twenty as sixteen plus four, then the rounding half-divisor.
                n_num   = (r_num <<< 4) + (r_num <<< 2) + NUM_W'(w_nr);
                n_den   = {w_nr[DVS_W-2:0], 1'b0};
                n_state = lcwtc_pkg::ST_START;
            end
            lcwtc_pkg::ST_START: begin
                w_req.start = 1'b1;
                n_neg       = r_num[NUM_W-1];
                n_state     = lcwtc_pkg::ST_WAIT;
            end
            lcwtc_pkg::ST_WAIT: begin
                if (w_div_done) begin
                    n_state = lcwtc_pkg::ST_POST;
                end
            end
            lcwtc_pkg::ST_POST: begin
                if ((r_kind == lcwtc_pkg::MODE_CAL) && !r_second) begin
                    // Calibration: the average less the zero offset, divided by the
                    // known weight. A known weight of zero yields zero.
                    n_num    = w_q_signed - w_zo_ext;
                    n_second = 1'b1;
                    if (w_cfg.known_weight == '0) begin
                        n_res   = '0;
                        n_state = lcwtc_pkg::ST_DONE;
                    end else begin
                        n_den   = w_cfg.known_weight;
                        n_state = lcwtc_pkg::ST_START;
                    end
                end else begin
                    n_res   = w_q_signed[RES_W-1:0];
                    n_state = lcwtc_pkg::ST_DONE;
                end
            end
            lcwtc_pkg::ST_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_value = r_res;
                    n_m_kind  = r_kind;
                    n_m_repl  = r_repl;
                    n_state   = lcwtc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lcwtc_pkg::ST_IDLE;
            end
        endcase

        // A mode write starts a fresh group.
        if (w_mode_wr) begin
            n_sum = '0;
            n_cnt = '0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(lcwtc_pkg::TDATA_W - RES_W){1'b0}}, r_m_value};
    assign o_m_tuser  = {r_m_repl, r_m_kind};

endmodule

[hw/rtl/lcwtc_chk.sv]
// Port-level checker for the load-cell weigh, tare and calibrate unit, with its bind.
// Depends on lcwtc_pkg for widths and kind codes.
module lcwtc_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [lcwtc_pkg::TDATA_W-1:0]  o_m_tdata,
    input logic [lcwtc_pkg::TUSER_W-1:0]  o_m_tuser
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // The replaced-ratio flag belongs to weigh results only.
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> o_m_tuser[1:0] == lcwtc_pkg::MODE_WEIGH)
        else $error("ratio flag on a non-weigh result");

    // A fresh result is loaded only from the final sequencer step, when samples are held off.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result appeared without a sequencer pass");

    // Reset empties the output register.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind load_cell_weigh_tare_calibrate_unit lcwtc_chk u_lcwtc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

[tb/load_cell_weigh_tare_calibrate_unit_tb.sv]
// Self-checking bench for the load-cell weigh, tare and calibrate unit: directed and random
// sample streams under changing register settings, checked against an in-bench predictor.
// Depends on lcwtc_pkg and load_cell_weigh_tare_calibrate_unit.
module load_cell_weigh_tare_calibrate_unit_tb;

    localparam int    CLK_PERIOD     = 10;
    localparam int    WEIGH_N        = lcwtc_pkg::WEIGH_SAMPLES_DEF;
    localparam int    CAL_N          = lcwtc_pkg::CAL_SAMPLES_DEF;
    localparam int    RANDOM_ITEMS   = 1300;
    localparam int    RES_W          = lcwtc_pkg::RES_W;
    localparam int    RAW_W          = lcwtc_pkg::RAW_W;
    localparam int    RATIO_W        = lcwtc_pkg::RATIO_W;
    localparam int    KW_W           = lcwtc_pkg::KW_W;
    localparam int    APB_AW         = lcwtc_pkg::APB_AW;
    localparam int    APB_DW         = lcwtc_pkg::APB_DW;
    localparam int    TDATA_W        = lcwtc_pkg::TDATA_W;
    localparam int    TUSER_W        = lcwtc_pkg::TUSER_W;
    // A calibrate result takes up to two divider passes; allow a good margin.
    localparam int    SETTLE_CYCLES  = 100;
    // This is far beyond the slowest correct run.
    localparam longint TIMEOUT_CYCLES = 1_000_000;
    // The mode register has no package code for its fourth value: samples are discarded.
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    // One expected transfer on the master stream, field by field.
    typedef struct {
        logic [RES_W-1:0] value;
        logic [1:0]       kind;
        logic             replaced;
    } t_weigh_result;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [RAW_W-1:0]    s_tdata  = '0;
    logic                m_tready = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;

    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [TDATA_W-1:0]  o_m_tdata;
    logic [TUSER_W-1:0]  o_m_tuser;
    logic [APB_DW-1:0]   o_prdata;
    logic                o_pready;

    // Raw codes waiting to be offered, and the results the predictor says must come out.
    logic [RAW_W-1:0]    raw_pending[$];
    t_weigh_result       results_due[$];

    // Idle percentages for each side, and the pause flag used to starve the sender.
    int                  send_idle_pct = 22;
    int                  recv_idle_pct = 87;
    bit                  hold_sender   = 1'b0;
    int                  mismatch_count = 0;

    // Predictor copy of the registers and of the running group.
    logic [1:0]          cfg_mode  = lcwtc_pkg::MODE_WEIGH;
    logic signed [RAW_W-1:0] cfg_zero = '0;
    logic [RATIO_W-1:0]  cfg_ratio = lcwtc_pkg::RATIO_RESET;
    logic [KW_W-1:0]     cfg_known = KW_W'(1);
    int                  grp_cnt   = 0;
    longint              grp_sum   = 0;

    load_cell_weigh_tare_calibrate_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // [23:0] raw_code
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),    // [24:0] result_value, [31:25] zero
        .o_m_tuser  (o_m_tuser),    // [1:0] result_kind, [2] ratio_replaced
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Reset is held at the start and never asserted again.
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Prints one line per mismatch and keeps the tally that decides the verdict.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Adds one accepted sample to the group and, when the group is complete, works out the
    // weight in tenths, the zero average or the calibrated ratio that the block must produce.
    task automatic accumulate_sample(logic [RAW_W-1:0] code);
        t_weigh_result res;
        longint        ratio;
        longint        diff;
        longint        avg;
        longint        val;
        int            need;
        if (cfg_mode == MODE_IGNORE) begin
            return;
        end
        grp_sum += longint'($signed(code));
        grp_cnt++;
        need = (cfg_mode == lcwtc_pkg::MODE_WEIGH) ? WEIGH_N : CAL_N;
        if (grp_cnt < need) begin
            return;
        end
        res.kind     = cfg_mode;
        res.replaced = 1'b0;
        if (cfg_mode == lcwtc_pkg::MODE_WEIGH) begin
            ratio = longint'(cfg_ratio);
            // An implausible ratio falls back to the nominal one and is flagged.
            if (cfg_ratio < lcwtc_pkg::RATIO_LOW || cfg_ratio > lcwtc_pkg::RATIO_HIGH) begin
                ratio        = longint'(lcwtc_pkg::RATIO_RESET);
                res.replaced = 1'b1;
            end
            diff = grp_sum - WEIGH_N * longint'(cfg_zero);
            // Rounding by adding a half before a division that truncates towards zero.
            val = (20 * diff + WEIGH_N * ratio) / (2 * WEIGH_N * ratio);
        end else begin
            avg = grp_sum / CAL_N;
            if (cfg_mode == lcwtc_pkg::MODE_TARE) begin
                val = avg;
            end else if (cfg_known == '0) begin
                val = 0;
            end else begin
                val = (avg - longint'(cfg_zero)) / longint'(cfg_known);
            end
        end
        res.value = RES_W'(val);
        results_due.push_back(res);
        grp_cnt = 0;
        grp_sum = 0;
    endtask

    // Compares one master-stream transfer with the oldest outstanding expectation.
    task automatic check_result(logic [TDATA_W-1:0] tdata, logic [TUSER_W-1:0] tuser);
        t_weigh_result want;
        if (results_due.size() == 0) begin
            report_mismatch("result with nothing outstanding", tdata, '0);
            return;
        end
        want = results_due.pop_front();
        if (tdata[RES_W-1:0] !== want.value) begin
            report_mismatch("result_value", 32'(tdata[RES_W-1:0]), 32'(want.value));
        end
        if (tuser[1:0] !== want.kind) begin
            report_mismatch("result_kind", 32'(tuser[1:0]), 32'(want.kind));
        end
        if (tuser[2] !== want.replaced) begin
            report_mismatch("ratio_replaced", 32'(tuser[2]), 32'(want.replaced));
        end
    endtask

    // Sender: offers the next pending code, holding it until the block takes it. Idle cycles
    // are only inserted once the previous offer has gone, so tvalid never drops under a stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_tready) begin
            if (raw_pending.size() != 0 && !hold_sender &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= raw_pending.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: values sampled here are those from before the edge, so a transfer is seen
    // exactly at the edge where both tvalid and tready are high.
    always @(posedge clk) begin
        if (rst_n) begin
            if (o_m_tvalid && m_tready) begin
                check_result(o_m_tdata, o_m_tuser);
            end
            if (s_tvalid && o_s_tready) begin
                accumulate_sample(s_tdata);
            end
        end
    end

    // Register write: setup cycle, then access cycle; the register takes the value at the edge
    // that closes the access phase, which is where the predictor copy is updated too. Bits
    // above the field are filled at random, since the block must ignore them.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] field_mask;
        case (idx)
            lcwtc_pkg::REG_MODE:  field_mask = 32'h3;
            lcwtc_pkg::REG_ZERO:  field_mask = 32'hFF_FFFF;
            lcwtc_pkg::REG_RATIO: field_mask = 32'hFF_FFFF;
            default:              field_mask = 32'hFFFF;
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= (value & field_mask) | ($urandom() & ~field_mask);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!o_pready) @(posedge clk);
        case (idx)
            lcwtc_pkg::REG_MODE: begin
                // A mode change throws away the group in progress.
                cfg_mode = value[1:0];
                grp_cnt  = 0;
                grp_sum  = 0;
            end
            lcwtc_pkg::REG_ZERO:  cfg_zero  = value[RAW_W-1:0];
            lcwtc_pkg::REG_RATIO: cfg_ratio = value[RATIO_W-1:0];
            default:              cfg_known = value[KW_W-1:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits until every code has been taken and every result has come out, then gives the
    // sequencer time to settle before the registers are touched again.
    task automatic wait_idle();
        do @(negedge clk);
        while (raw_pending.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [RAW_W-1:0] pick_code();
        logic [RAW_W-1:0] code;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       code = 24'h000000;
                    1:       code = 24'h7F_FFFF;
                    2:       code = 24'h80_0000;
                    default: code = 24'hFF_FFFF;
                endcase
            end
            1, 2, 3: code = RAW_W'($urandom());
            // Most samples sit near the zero point, as a real load would.
            default: code = RAW_W'(longint'(cfg_zero) + longint'($urandom_range(0, 4_000_000))
                                   - 2_000_000);
        endcase
        return code;
    endfunction

    function automatic logic [31:0] pick_ratio();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 5))
                    0:       return 32'd0;
                    1:       return 32'd399;
                    2:       return 32'd400;
                    3:       return 32'd440;
                    4:       return 32'd441;
                    default: return 32'hFF_FFFF;
                endcase
            end
            1:       return 32'($urandom() & 32'hFF_FFFF);
            default: return 32'($urandom_range(400, 440));
        endcase
    endfunction

    function automatic logic [31:0] pick_zero();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 2))
                    0:       return 32'h80_0000;
                    1:       return 32'h7F_FFFF;
                    default: return 32'h0;
                endcase
            end
            1:       return 32'($urandom() & 32'hFF_FFFF);
            default: return 32'(int'($urandom_range(0, 200_000)) - 100_000);
        endcase
    endfunction

    function automatic logic [31:0] pick_known();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 2))
                    0:       return 32'd0;
                    1:       return 32'd1;
                    default: return 32'd65535;
                endcase
            end
            1, 2:    return 32'($urandom_range(1, 50));
            default: return 32'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [1:0] pick_mode();
        case ($urandom_range(0, 15))
            0:              return MODE_IGNORE;
            1, 2, 3, 4, 5:  return lcwtc_pkg::MODE_WEIGH;
            6, 7, 8, 9, 10: return lcwtc_pkg::MODE_TARE;
            default:        return lcwtc_pkg::MODE_CAL;
        endcase
    endfunction

    initial begin
        int counted;
        int phase;
        int phase_len;
        int i;
        counted = 0;
        phase   = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);

        // Directed part. Largest positive samples against the most negative zero point give
        // the largest weight the sum can hold; the reverse gives the smallest.
        write_reg(lcwtc_pkg::REG_ZERO, 32'h80_0000);
        repeat (WEIGH_N) raw_pending.push_back(24'h7F_FFFF);
        wait_idle();
        write_reg(lcwtc_pkg::REG_ZERO, 32'h7F_FFFF);
        repeat (WEIGH_N) raw_pending.push_back(24'h80_0000);
        wait_idle();

        // A ratio of zero is out of range and must be replaced by the nominal one.
        write_reg(lcwtc_pkg::REG_ZERO, 32'h0);
        write_reg(lcwtc_pkg::REG_RATIO, 32'h0);
        raw_pending.push_back(24'h000000);
        raw_pending.push_back(24'hFF_FFFF);
        raw_pending.push_back(24'h000001);
        wait_idle();

        // The largest ratio is out of range as well. Two samples are left in the group, and
        // the following mode change must throw them away.
        write_reg(lcwtc_pkg::REG_RATIO, 32'hFF_FFFF);
        raw_pending.push_back(24'h7F_FFFF);
        raw_pending.push_back(24'h7F_FFFF);
        wait_idle();
        write_reg(lcwtc_pkg::REG_MODE, 32'(lcwtc_pkg::MODE_TARE));
        raw_pending.push_back(24'h7F_FFFF);
        raw_pending.push_back(24'h7F_FFFF);
        raw_pending.push_back(24'h80_0000);
        raw_pending.push_back(24'h12_3456);
        raw_pending.push_back(24'hFE_DCBA);
        wait_idle();

        // Calibration with a known weight of zero yields zero whatever the samples are.
        write_reg(lcwtc_pkg::REG_MODE, 32'(lcwtc_pkg::MODE_CAL));
        write_reg(lcwtc_pkg::REG_KNOWN, 32'h0);
        write_reg(lcwtc_pkg::REG_ZERO, 32'h80_0000);
        repeat (CAL_N) raw_pending.push_back(24'h7F_FFFF);
        wait_idle();

        // The unused mode takes samples and gives nothing back.
        write_reg(lcwtc_pkg::REG_MODE, 32'(MODE_IGNORE));
        raw_pending.push_back(24'h55_AA55);
        raw_pending.push_back(24'hAA_55AA);
        raw_pending.push_back(24'h7F_FFFF);
        wait_idle();

        // Random part: each phase rewrites some registers, then streams codes. Leaving the mode
        // alone lets a partial group run on across writes to the other registers.
        write_reg(lcwtc_pkg::REG_MODE, 32'(lcwtc_pkg::MODE_WEIGH));
        while (counted < RANDOM_ITEMS) begin
            if (counted >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (counted >= RANDOM_ITEMS / 3) begin
                send_idle_pct = 87;
                recv_idle_pct = 22;
            end
            if ($urandom_range(0, 3) != 0) write_reg(lcwtc_pkg::REG_MODE, 32'(pick_mode()));
            if ($urandom_range(0, 1) != 0) write_reg(lcwtc_pkg::REG_ZERO, pick_zero());
            if ($urandom_range(0, 1) != 0) write_reg(lcwtc_pkg::REG_RATIO, pick_ratio());
            if ($urandom_range(0, 1) != 0) write_reg(lcwtc_pkg::REG_KNOWN, pick_known());
            phase_len = (cfg_mode == MODE_IGNORE) ? $urandom_range(1, 6) : $urandom_range(8, 40);
            for (i = 0; i < phase_len; i++) begin
                raw_pending.push_back(pick_code());
            end
            if (cfg_mode != MODE_IGNORE) begin
                counted += phase_len;
            end
            // Now and then the sender stops part-way through a phase until the block has
            // delivered everything it owes.
            if (phase % 8 == 4) begin
                while (raw_pending.size() > phase_len / 2) @(negedge clk);
                hold_sender = 1'b1;
                while (results_due.size() != 0) @(negedge clk);
                hold_sender = 1'b0;
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Verification failed");
        $finish;
    end

endmodule
